// File: rtl/mbsp_pkg.sv
// ---------------------------------------------------------------------------
// mbsp_pkg
// Shared types and constants for the MIDI byte stream parser.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package mbsp_pkg;

  // Status byte codes
  localparam logic [7:0] SYSEX_START     = 8'hF0;
  localparam logic [7:0] SYSEX_END       = 8'hF7;
  localparam logic [7:0] REALTIME_FIRST  = 8'hF8;
  localparam logic [7:0] NO_STATUS       = 8'h00;

  // Upper nibble of channel messages
  localparam logic [3:0] HI_NOTE_OFF     = 4'h8;
  localparam logic [3:0] HI_NOTE_ON      = 4'h9;
  localparam logic [3:0] HI_CONTROL      = 4'hB;
  localparam logic [3:0] HI_PROGRAM      = 4'hC;
  localparam logic [3:0] HI_CHAN_PRESS   = 4'hD;
  localparam logic [3:0] HI_PITCH_BEND   = 4'hE;
  localparam logic [3:0] HI_SYSTEM       = 4'hF;

  // Sustain pedal controller number and on threshold
  localparam logic [6:0] CC_SUSTAIN      = 7'h40;
  localparam logic [6:0] SUSTAIN_THRESH  = 7'h40;

  localparam int unsigned NUM_CHANNELS   = 4;

  typedef enum logic [2:0] {
    KIND_NOTE_OFF = 3'd0,
    KIND_NOTE_ON  = 3'd1,
    KIND_SUSTAIN  = 3'd2,
    KIND_PROGRAM  = 3'd3,
    KIND_BEND     = 3'd4
  } event_kind_t;

  typedef struct packed {
    logic [7:0] current_status;
    logic [7:0] running_status;
    logic [1:0] param_count;
    logic [6:0] first_data_byte;
    logic       sysex_active;
  } parser_state_t;

  typedef struct packed {
    event_kind_t kind;
    logic [1:0]  channel;
    logic [7:0]  value;
  } midi_event_t;

endpackage

// File: rtl/mbsp_decode.sv
// ---------------------------------------------------------------------------
// mbsp_decode
// Combinational byte decode: next parser state and the optional event.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module mbsp_decode (
  input  logic [7:0]            rx_byte,
  input  logic [3:0]            channel_enable_mask,
  input  mbsp_pkg::parser_state_t state_cur,
  output mbsp_pkg::parser_state_t state_next,
  output logic                  emit,
  output mbsp_pkg::midi_event_t ev
);
  import mbsp_pkg::*;

  logic [6:0] data7;
  logic [1:0] count_inc;
  logic [1:0] msg_size;
  logic [3:0] hi;
  logic [3:0] chan;
  logic [6:0] first_byte;
  logic       chan_on;

  assign data7      = rx_byte[6:0];
  assign count_inc  = state_cur.param_count + 2'd1;
  assign hi         = state_cur.current_status[7:4];
  assign chan       = state_cur.current_status[3:0];
  // first data byte as it stands after this byte is taken
  assign first_byte = (state_cur.param_count == 2'd0) ? data7 : state_cur.first_data_byte;
  assign msg_size   = (hi == HI_PROGRAM || hi == HI_CHAN_PRESS) ? 2'd1 : 2'd2;
  assign chan_on    = (chan < 4'(NUM_CHANNELS)) && channel_enable_mask[chan[1:0]];

  always_comb begin
    state_next = state_cur;
    emit       = 1'b0;
    ev.kind    = KIND_NOTE_OFF;
    ev.channel = chan[1:0];
    ev.value   = {1'b0, first_byte};

    if (rx_byte[7]) begin
      // status bytes; real-time bytes only pass through
      if (rx_byte == SYSEX_START) state_next.sysex_active = 1'b1;
      if (rx_byte == SYSEX_END)   state_next.sysex_active = 1'b0;
      if (rx_byte < REALTIME_FIRST) begin
        state_next.current_status = rx_byte;
        state_next.running_status = (rx_byte < SYSEX_START) ? rx_byte : NO_STATUS;
        state_next.param_count    = 2'd0;
      end
    end else if (state_cur.param_count != 2'd2 && state_cur.current_status != NO_STATUS) begin
      // data byte with a known status
      state_next.first_data_byte = first_byte;
      state_next.param_count     = count_inc;
      if (!state_cur.sysex_active && hi != HI_SYSTEM && count_inc >= msg_size) begin
        // message complete
        state_next.param_count    = 2'd0;
        state_next.current_status = state_cur.running_status;
        if (chan_on) begin
          case (hi)
            HI_NOTE_OFF: begin
              emit    = 1'b1;
              ev.kind = KIND_NOTE_OFF;
            end
            HI_NOTE_ON: begin
              emit    = 1'b1;
              ev.kind = (data7 != 7'd0) ? KIND_NOTE_ON : KIND_NOTE_OFF;
            end
            HI_CONTROL: begin
              emit     = (first_byte == CC_SUSTAIN);
              ev.kind  = KIND_SUSTAIN;
              ev.value = {7'd0, (data7 >= SUSTAIN_THRESH)};
            end
            HI_PROGRAM: begin
              emit    = 1'b1;
              ev.kind = KIND_PROGRAM;
            end
            HI_PITCH_BEND: begin
              emit     = 1'b1;
              ev.kind  = KIND_BEND;
              ev.value = {data7, data7[6]};
            end
            default: begin
              emit = 1'b0;
            end
          endcase
        end
      end
    end
  end

endmodule

// File: rtl/mbsp_out_reg.sv
// ---------------------------------------------------------------------------
// mbsp_out_reg
// Result register holding one event word until the sink takes it.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module mbsp_out_reg (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  mbsp_pkg::midi_event_t ev_in,
  output logic                  free,
  output logic                  event_valid,
  input  logic                  event_ready,
  output mbsp_pkg::midi_event_t ev_out
);
  import mbsp_pkg::*;

  // register accepts a new word when empty or being drained
  assign free = !event_valid || event_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      event_valid <= 1'b0;
    end else if (load) begin
      event_valid <= 1'b1;
    end else if (event_ready) begin
      event_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ev_out <= ev_in;
    end
  end

endmodule

// File: rtl/midi_byte_stream_parser_unit.sv
// A byte is registered on accept, and its event is loaded into the result
// register as the byte leaves the input register, which may wait on a stall.
// Throughput: one byte per cycle while no event waits on the result register.
// A byte with an event waits only while the result register is full and not
// being drained. Reset: rst (synchronous) clears parser state, empties both
// registers and sets the enable mask register to 1. No clearing pass.
// ---------------------------------------------------------------------------
// midi_byte_stream_parser_unit
// Running status MIDI parser yielding note, sustain, program and bend events.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module midi_byte_stream_parser_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] rx_byte,
  input  logic       rx_byte_valid,
  output logic       rx_byte_ready,
  input  logic [3:0] channel_enable_mask,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  output logic [2:0] event_kind,
  output logic [1:0] event_channel,
  output logic [7:0] event_value,
  output logic       event_valid,
  input  logic       event_ready
);
  import mbsp_pkg::*;

  logic          in_valid;
  logic [7:0]    in_byte;
  logic [3:0]    enable_mask;
  parser_state_t state;
  parser_state_t state_next;
  logic          emit;
  midi_event_t   ev;
  midi_event_t   ev_out;
  logic          out_free;
  logic          advance;

  // config register, always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable_mask <= 4'd1;
    end else if (cfg_valid) begin
      enable_mask <= channel_enable_mask;
    end
  end

  // input register stage
  assign advance       = in_valid && (!emit || out_free);
  assign rx_byte_ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (rx_byte_ready) begin
      in_valid <= rx_byte_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_byte_ready && rx_byte_valid) begin
      in_byte <= rx_byte;
    end
  end

  // parser state, updated as each byte leaves the input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      state.current_status  <= NO_STATUS;
      state.running_status  <= NO_STATUS;
      state.param_count     <= 2'd0;
      state.first_data_byte <= 7'd0;
      state.sysex_active    <= 1'b0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  mbsp_decode u_decode (
    .rx_byte             (in_byte),
    .channel_enable_mask (enable_mask),
    .state_cur           (state),
    .state_next          (state_next),
    .emit                (emit),
    .ev                  (ev)
  );

  mbsp_out_reg u_out_reg (
    .clk         (clk),
    .rst         (rst),
    .load        (advance && emit),
    .ev_in       (ev),
    .free        (out_free),
    .event_valid (event_valid),
    .event_ready (event_ready),
    .ev_out      (ev_out)
  );

  assign event_kind    = ev_out.kind;
  assign event_channel = ev_out.channel;
  assign event_value   = ev_out.value;

endmodule

// File: rtl/mbsp_checker.sv
// ---------------------------------------------------------------------------
// mbsp_checker
// Port-level checks on the parser's event stream.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module mbsp_checker (
  input logic       clk,
  input logic       rst,
  input logic       rx_byte_ready,
  input logic [2:0] event_kind,
  input logic [1:0] event_channel,
  input logic [7:0] event_value,
  input logic       event_valid,
  input logic       event_ready
);
  import mbsp_pkg::*;

  // output register is empty after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !event_valid)
    else $error("event_valid high after reset");

  // an empty result register never blocks the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !event_valid |-> rx_byte_ready)
    else $error("input stalled with empty result register");

  // a stalled event word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    event_valid && !event_ready |=>
      event_valid && $stable(event_kind) && $stable(event_channel) && $stable(event_value))
    else $error("event word changed while stalled");

  // bend value repeats its top bit at the bottom
  a_bend_value: assert property (@(posedge clk) disable iff (rst)
    event_valid && event_kind == KIND_BEND |-> event_value[0] == event_value[7])
    else $error("bend value malformed");

  // sustain is a flag; note and program values are 7 bits
  a_value_range: assert property (@(posedge clk) disable iff (rst)
    event_valid |->
      (event_kind == KIND_SUSTAIN && event_value[7:1] == 7'd0) ||
      ((event_kind == KIND_NOTE_OFF || event_kind == KIND_NOTE_ON ||
        event_kind == KIND_PROGRAM) && !event_value[7]) ||
      event_kind == KIND_BEND)
    else $error("event kind or value out of range");

endmodule

bind midi_byte_stream_parser_unit mbsp_checker u_mbsp_checker (.*);

// File: bench/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the MIDI byte stream parser. A scoreboard class
// tracks the running status state machine, predicts each event from the
// bytes that the block accepts and checks the events that it delivers.
// Stimulus is a short hand-written stream followed by random well-formed
// messages, sysex transfers, system common messages and noise, under
// several channel masks and with random idling on both sides.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import mbsp_pkg::*;

  // Parser state tracker and queue of events still due from the block
  class midi_event_tracker;
    logic [7:0]  status_q;
    logic [7:0]  running_q;
    bit [1:0]    data_count;
    bit [6:0]    first_data;
    bit          in_sysex;
    bit [3:0]    chan_mask;
    midi_event_t events_due[$];
    int unsigned n_checked;
    int unsigned n_errors;

    function new();
      status_q   = NO_STATUS;
      running_q  = NO_STATUS;
      data_count = 2'd0;
      first_data = 7'd0;
      in_sysex   = 1'b0;
      chan_mask  = 4'h1;
      n_checked  = 0;
      n_errors   = 0;
    endfunction

    function void set_mask(bit [3:0] m);
      chan_mask = m;
    endfunction

    function int pending();
      return events_due.size();
    endfunction

    function void push_event(event_kind_t k, logic [1:0] c, logic [7:0] v);
      midi_event_t ev;
      ev.kind    = k;
      ev.channel = c;
      ev.value   = v;
      events_due.push_back(ev);
    endfunction

    // Advance the parser by one accepted byte
    function void take_byte(logic [7:0] b);
      logic [3:0] hi;
      logic [3:0] ch;
      logic [6:0] d;
      int         size;
      if (b[7]) begin
        if (b == SYSEX_START) in_sysex = 1'b1;
        if (b == SYSEX_END) in_sysex = 1'b0;
        if (b < REALTIME_FIRST) begin
          status_q   = b;
          running_q  = (b < SYSEX_START) ? b : NO_STATUS;
          data_count = 2'd0;
        end
        return;
      end
      // dropped: no status yet, or message already full
      if (data_count >= 2'd2 || status_q == NO_STATUS) return;
      d = b[6:0];
      if (data_count == 2'd0) first_data = d;
      data_count = data_count + 2'd1;
      if (in_sysex) return;
      hi = status_q[7:4];
      if (hi == HI_SYSTEM) return;
      ch   = status_q[3:0];
      size = (hi == HI_PROGRAM || hi == HI_CHAN_PRESS) ? 1 : 2;
      if (data_count < size) return;
      // complete message; channels above three never pass
      if (ch < NUM_CHANNELS && chan_mask[ch[1:0]]) begin
        case (hi)
          HI_NOTE_OFF: push_event(KIND_NOTE_OFF, ch[1:0], {1'b0, first_data});
          HI_NOTE_ON: begin
            if (d != 7'd0) push_event(KIND_NOTE_ON, ch[1:0], {1'b0, first_data});
            else push_event(KIND_NOTE_OFF, ch[1:0], {1'b0, first_data});
          end
          HI_CONTROL: begin
            if (first_data == CC_SUSTAIN)
              push_event(KIND_SUSTAIN, ch[1:0], (d >= SUSTAIN_THRESH) ? 8'd1 : 8'd0);
          end
          HI_PROGRAM: push_event(KIND_PROGRAM, ch[1:0], {1'b0, first_data});
          HI_PITCH_BEND: push_event(KIND_BEND, ch[1:0], {d, d[6]});
          default: ;
        endcase
      end
      data_count = 2'd0;
      status_q   = running_q;
    endfunction

    // Compare one delivered event with the oldest one due
    function void check_event(logic [2:0] k, logic [1:0] c, logic [7:0] v);
      midi_event_t ev;
      n_checked++;
      if (events_due.size() == 0) begin
        n_errors++;
        if (n_errors <= 10)
          $display("%0t: unexpected event kind=%0d chan=%0d value=%02h",
                   $realtime, k, c, v);
        return;
      end
      ev = events_due.pop_front();
      if (k !== ev.kind || c !== ev.channel || v !== ev.value) begin
        n_errors++;
        if (n_errors <= 10)
          $display({"%0t: event mismatch exp kind=%0d chan=%0d value=%02h, ",
                    "got kind=%0d chan=%0d value=%02h"},
                   $realtime, ev.kind, ev.channel, ev.value, k, c, v);
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic [7:0] rx_byte = 8'h00;
  logic       rx_byte_valid = 1'b0;
  logic       rx_byte_ready;
  logic [3:0] channel_enable_mask = 4'h1;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [2:0] event_kind;
  logic [1:0] event_channel;
  logic [7:0] event_value;
  logic       event_valid;
  logic       event_ready = 1'b0;

  midi_event_tracker tracker = new();

  bit          calm = 1'b0;      // no idling on either side
  bit          hold_req = 1'b0;  // asks the receiver for a long hold-off
  bit          have_running = 1'b0;
  int unsigned n_sent = 0;
  int unsigned n_cfg = 0;

  logic [7:0] directed_bytes [26] = '{
    8'h00,                     // data with no status
    8'h90, 8'h3C, 8'h64,       // note on
    8'h3C, 8'h00,              // running status, velocity zero
    8'hF8,                     // real-time
    8'h80, 8'h7F, 8'h7F,       // note off, top values
    8'hB0, 8'h40, 8'h40,       // sustain on at threshold
    8'h40, 8'h3F,              // sustain off just below
    8'hC0, 8'h7F,              // program change
    8'hD0, 8'h55,              // channel pressure, no event
    8'hE0, 8'h7F, 8'hF8, 8'h7F, // bend with real-time inside
    8'hF0, 8'h12, 8'hF7        // short sysex
  };

  midi_byte_stream_parser_unit u_dut (
    .clk                 (clk),
    .rst                 (rst),
    .rx_byte             (rx_byte),
    .rx_byte_valid       (rx_byte_valid),
    .rx_byte_ready       (rx_byte_ready),
    .channel_enable_mask (channel_enable_mask),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .event_kind          (event_kind),
    .event_channel       (event_channel),
    .event_value         (event_value),
    .event_valid         (event_valid),
    .event_ready         (event_ready)
  );

  // 4 ns clock
  initial begin
    forever #2 clk = ~clk;
  end

  // Run limit
  initial begin
    #2_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

  // Receiver: random stalls, long hold-off on request
  always @(negedge clk) begin
    int hold_left;
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = 300;
    end
    if (hold_left > 0) begin
      hold_left--;
      event_ready <= 1'b0;
    end else if (calm) begin
      event_ready <= 1'b1;
    end else begin
      event_ready <= ($urandom_range(99) >= 33);
    end
  end

  // Event checker
  always @(posedge clk) begin
    if (!rst && event_valid && event_ready)
      tracker.check_event(event_kind, event_channel, event_value);
  end

  // Offer one word; entered and left at a falling edge
  task automatic send_byte(input logic [7:0] b);
    if (!calm && $urandom_range(99) < 16) begin
      rx_byte_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    rx_byte       <= b;
    rx_byte_valid <= 1'b1;
    do @(posedge clk); while (!rx_byte_ready);
    tracker.take_byte(b);
    n_sent++;
    @(negedge clk);
  endtask

  task automatic send_data();
    send_byte({1'b0, 7'($urandom_range(127))});
  endtask

  // Channel message, sometimes relying on running status
  task automatic send_channel_msg();
    logic [3:0] hi;
    logic [3:0] ch;
    logic [6:0] d1;
    logic [6:0] d2;
    int         size;
    hi   = 4'h8 + 4'($urandom_range(6));
    ch   = ($urandom_range(99) < 80) ? 4'($urandom_range(3)) : 4'($urandom_range(15, 4));
    size = (hi == HI_PROGRAM || hi == HI_CHAN_PRESS) ? 1 : 2;
    d1   = 7'($urandom_range(127));
    d2   = 7'($urandom_range(127));
    if (hi == HI_CONTROL && $urandom_range(1) == 1) d1 = CC_SUSTAIN;
    if (hi == HI_NOTE_ON && $urandom_range(3) == 0) d2 = 7'd0;
    if (!have_running || $urandom_range(99) < 60) send_byte({hi, ch});
    if ($urandom_range(99) < 8) send_byte(8'($urandom_range(255, REALTIME_FIRST)));
    send_byte({1'b0, d1});
    if (size == 2) send_byte({1'b0, d2});
    have_running = 1'b1;
  endtask

  // Sysex transfer, possibly with a channel status inside it
  task automatic send_sysex();
    send_byte(SYSEX_START);
    repeat ($urandom_range(4)) send_data();
    if ($urandom_range(3) == 0) begin
      send_byte({4'h8 + 4'($urandom_range(6)), 4'($urandom_range(3))});
      send_data();
      send_data();
    end
    if ($urandom_range(99) < 15) send_byte(8'($urandom_range(255, REALTIME_FIRST)));
    send_byte(SYSEX_END);
    have_running = 1'b0;
  endtask

  // System common status with trailing data, some of it overlong
  task automatic send_common();
    send_byte(8'($urandom_range(246, 241)));
    repeat ($urandom_range(3)) send_data();
    have_running = 1'b0;
  endtask

  task automatic run_random(input int unsigned upto);
    int unsigned r;
    while (n_sent < upto) begin
      r = $urandom_range(99);
      if (r < 70) send_channel_msg();
      else if (r < 80) send_sysex();
      else if (r < 88) send_common();
      else repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
    end
  endtask

  // Let all due events drain and the pipeline empty
  task automatic settle();
    rx_byte_valid <= 1'b0;
    while (tracker.pending() > 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_mask(input logic [3:0] m);
    channel_enable_mask <= m;
    cfg_valid           <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    tracker.set_mask(m);
    n_cfg++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Main sequence
  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_bytes[i]) send_byte(directed_bytes[i]);

    settle();
    write_mask(4'hF);
    run_random(380);

    settle();
    write_mask(4'h0);
    run_random(480);

    // stretch with no idling
    settle();
    write_mask(4'hA);
    calm = 1'b1;
    run_random(730);
    calm = 1'b0;

    // receiver holds off while bytes keep coming
    settle();
    write_mask(4'h5);
    hold_req = 1'b1;
    run_random(900);

    settle();
    write_mask(4'($urandom_range(15)));
    run_random(1400);

    settle();
    repeat (10) @(negedge clk);

    $display("tb_top: %0d bytes, %0d events checked, %0d mask writes, %0d mismatches",
             n_sent, tracker.n_checked, n_cfg, tracker.n_errors);
    if (tracker.n_errors == 0 && tracker.pending() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/mbsp_pkg.sv
rtl/mbsp_decode.sv
rtl/mbsp_out_reg.sv
rtl/midi_byte_stream_parser_unit.sv
rtl/mbsp_checker.sv
bench/tb_top.sv
